// ===== rtl/wcfa_pkg.sv =====
// Shared types, constants and table builder for the Wolf Coulomb force accumulator.
package wcfa_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ALPHA_MILLI = 250;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int TABLE_SPAN  = 2 * TABLE_DEPTH;

   localparam int SUM_WIDTH  = 48;
   localparam int AXIS_COUNT = 3;
   localparam int AXIS_AW    = $clog2(AXIS_COUNT);

   localparam logic [AXIS_AW-1:0] AXIS_X = AXIS_AW'(0);
   localparam logic [AXIS_AW-1:0] AXIS_Y = AXIS_AW'(1);
   localparam logic [AXIS_AW-1:0] AXIS_Z = AXIS_AW'(2);

   localparam logic [1:0] CSR_CUTOFF_SQUARED   = 2'd0;
   localparam logic [1:0] CSR_COULOMB_CONSTANT = 2'd1;
   localparam logic [1:0] CSR_FORCE_SHIFT      = 2'd2;

   localparam logic [63:0] M32                 = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] ONE_Q32             = 64'h0000_0001_0000_0000;
   localparam logic [63:0] EXP_M1_Q32          = 64'd1580030169;
   localparam logic [63:0] TWO_OVER_SQRTPI_Q32 = 64'd4846351619;
   localparam logic [63:0] AS_P_Q32            = 64'd1406993061;
   localparam logic signed [63:0] AS_A1 = 64'sd1094484766;
   localparam logic signed [63:0] AS_A2 = -64'sd1221904177;
   localparam logic signed [63:0] AS_A3 = 64'sd6104925531;
   localparam logic signed [63:0] AS_A4 = -64'sd6241240432;
   localparam logic signed [63:0] AS_A5 = 64'sd4558701605;
   localparam logic [63:0] ALPHA_Q32 = (64'(ALPHA_MILLI) << 32) / 64'd1000;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [15:0] origin_charge;
      logic signed [31:0] neighbor_x;
      logic signed [31:0] neighbor_y;
      logic signed [31:0] neighbor_z;
      logic signed [15:0] neighbor_charge;
      logic               first_neighbor;
      logic               last_neighbor;
   } req_payload_type;

   typedef struct packed {
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
   } rsp_payload_type;

   // Each entry holds the damped kernel in the upper half, 1/r in the lower half.
   typedef logic [63:0] rom_type [TABLE_DEPTH];

   function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b,
                                                 int unsigned sh, logic [63:0] cap);
      logic [127:0] p;
      logic [127:0] s;
      p = {64'd0, a} * {64'd0, b};
      s = p >> sh;
      if (s[127:64] != 64'd0) return cap;
      if (s[63:0] > cap) return cap;
      return s[63:0];
   endfunction

   function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
      return mul_shift_sat(a, b, 32, '1);
   endfunction

   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic signed [63:0] smul_q32(logic signed [63:0] v, logic [63:0] t);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] p;
      neg = v[63];
      mag = neg ? (64'd0 - 64'(v)) : 64'(v);
      p   = mul_q32(mag, t);
      return neg ? $signed(64'd0 - p) : $signed(p);
   endfunction

   function automatic logic [63:0] isqrt64(logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] probe;
      v     = v_in;
      res   = '0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 64'd0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] exp_neg_q32(logic [63:0] y);
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] v;
      n    = y >> 32;
      f    = y & M32;
      term = ONE_Q32;
      pos  = ONE_Q32;
      neg  = '0;
      for (int k = 1; k <= 20; k++) begin
         term = udiv64(mul_q32(term, f), 64'(k));
         if (k % 2 == 1) neg = neg + term;
         else            pos = pos + term;
      end
      v = (pos > neg) ? pos - neg : 64'd0;
      if (n >= 64'd64) return 64'd0;
      while (n != 64'd0 && v != 64'd0) begin
         v = mul_q32(v, EXP_M1_Q32);
         n = n - 64'd1;
      end
      return v;
   endfunction

   function automatic logic [31:0] to_q16(logic [63:0] q32);
      logic [63:0] r;
      r = (q32 + 64'h8000) >> 16;
      return (r > M32) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type            t;
      logic [63:0]        a;
      logic [63:0]        a2;
      logic [63:0]        c;
      logic [63:0]        r2;
      logic [63:0]        r;
      logic [63:0]        ir;
      logic [63:0]        ir2;
      logic [63:0]        ir3;
      logic [63:0]        x;
      logic [63:0]        e;
      logic [63:0]        tt;
      logic [63:0]        erfcv;
      logic [63:0]        h;
      logic signed [63:0] acc;
      a  = ALPHA_Q32;
      a2 = mul_q32(a, a);
      c  = mul_q32(a, TWO_OVER_SQRTPI_Q32);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         r2 = (64'(2 * i + 1) << 40) / TABLE_SPAN;
         r  = isqrt64(r2 << 16) << 8;
         if (r == 64'd0) r = 64'd1;
         ir    = udiv64('1, r);
         ir2   = mul_q32(ir, ir);
         ir3   = mul_q32(ir2, ir);
         x     = mul_q32(a, r);
         e     = exp_neg_q32(mul_q32(a2, r2));
         tt    = udiv64('1, ONE_Q32 + mul_q32(AS_P_Q32, x));
         acc   = AS_A5;
         acc   = AS_A4 + smul_q32(acc, tt);
         acc   = AS_A3 + smul_q32(acc, tt);
         acc   = AS_A2 + smul_q32(acc, tt);
         acc   = AS_A1 + smul_q32(acc, tt);
         acc   = smul_q32(acc, tt);
         erfcv = acc[63] ? 64'd0 : mul_q32(64'(acc), e);
         h     = mul_q32(erfcv, ir3) + mul_q32(mul_q32(c, e), ir2);
         t[i]  = {to_q16(h), to_q16(ir)};
      end
      return t;
   endfunction

   localparam rom_type KERNEL_ROM = build_rom();

endpackage

// ===== rtl/wolf_coulomb_force_accumulator.sv =====
// Wolf damped, shifted-force Coulomb pair force accumulator (top level).
// One transaction is worked at a time; every product goes through one shared multiplier.
// A pair outside the cutoff skips the table and force products; a last pair then shows its
// result, waiting only while the output register holds an untaken result.
// Reset (synchronous) clears the control state, CSRs and sum valid flags, not the sum RAM.
module wolf_coulomb_force_accumulator
   import wcfa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_wdata
);

   // Sequencer states. Each multiply state waits for the shared multiplier.
   localparam logic [3:0] ST_IDLE        = 4'd0;
   localparam logic [3:0] ST_SQUARE      = 4'd1;
   localparam logic [3:0] ST_CUTOFF      = 4'd2;
   localparam logic [3:0] ST_TABLE       = 4'd3;
   localparam logic [3:0] ST_SHIFT_MUL   = 4'd4;
   localparam logic [3:0] ST_CHARGE_MUL  = 4'd5;
   localparam logic [3:0] ST_KERNEL_MUL  = 4'd6;
   localparam logic [3:0] ST_AXIS_MUL    = 4'd7;
   localparam logic [3:0] ST_SUM_READ    = 4'd8;
   localparam logic [3:0] ST_SUM_WRITE   = 4'd9;
   localparam logic [3:0] ST_EMIT        = 4'd10;

   localparam logic [63:0] KERNEL_CAP = 64'h4000_0000_0000_0000;
   localparam logic [63:0] FORCE_CAP  = 64'h0000_8000_0000_0000;
   localparam logic signed [49:0] SUM_HI = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] SUM_LO = -50'sh0_8000_0000_0000;

   // Configuration registers.
   logic [31:0] cutoff_ff;
   logic [31:0] coulomb_ff;
   logic [31:0] fshift_ff;

   // Control state.
   logic [3:0]         state_ff, state_in;
   logic [AXIS_AW-1:0] axis_ff, axis_in;
   logic [2:0]         sum_valid_ff, sum_valid_in;
   logic               mul_start_ff, mul_start_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-transaction working registers.
   logic [23:0]        md_ff [AXIS_COUNT];
   logic [23:0]        md_in [AXIS_COUNT];
   logic [2:0]         dneg_ff, dneg_in;
   logic               near_ff, near_in;
   logic               hit_ff, hit_in;
   logic               first_ff, first_in;
   logic               last_ff, last_in;
   logic [30:0]        qq_mag_ff, qq_mag_in;
   logic               qq_neg_ff, qq_neg_in;
   logic [49:0]        ss_ff, ss_in;
   logic [63:0]        rom_ff;
   logic [49:0]        g_ff, g_in;
   logic [62:0]        m2_ff, m2_in;
   logic [47:0]        c_ff, c_in;
   logic [47:0]        res_ff [AXIS_COUNT];
   logic [47:0]        res_in [AXIS_COUNT];
   logic [63:0]        mul_a_ff, mul_a_in;
   logic [63:0]        mul_b_ff, mul_b_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   // Datapath wires.
   logic               mul_done;
   logic [127:0]       mul_prod;
   logic               sum_we;
   logic [47:0]        sum_wdata;
   logic [47:0]        sum_rdata;
   logic [32:0]        d_x, d_y, d_z;
   logic [32:0]        mag_x, mag_y, mag_z;
   logic signed [31:0] qq;
   logic [31:0]        qq_abs;
   logic [23:0]        md_next;
   logic [31:0]        fs_mag;
   logic [49:0]        g_mag;
   logic [47:0]        fs_term;
   logic [31:0]        h_val;
   logic [63:0]        kernel_raw;
   logic [62:0]        m2_sat;
   logic [63:0]        force_raw;
   logic [47:0]        c_sat;
   logic [TABLE_AW-1:0] table_idx;
   logic               in_cutoff;
   logic               c_neg;
   logic [48:0]        c_signed;
   logic [47:0]        sum_old;
   logic signed [49:0] sum_wide;
   logic [47:0]        sum_sat;

   // Difference vector, its magnitudes and the charge product, taken at acceptance.
   always_comb begin
      d_x    = {req_data.origin_x[31], req_data.origin_x}
             - {req_data.neighbor_x[31], req_data.neighbor_x};
      d_y    = {req_data.origin_y[31], req_data.origin_y}
             - {req_data.neighbor_y[31], req_data.neighbor_y};
      d_z    = {req_data.origin_z[31], req_data.origin_z}
             - {req_data.neighbor_z[31], req_data.neighbor_z};
      mag_x  = d_x[32] ? (33'd0 - d_x) : d_x;
      mag_y  = d_y[32] ? (33'd0 - d_y) : d_y;
      mag_z  = d_z[32] ? (33'd0 - d_z) : d_z;
      qq     = req_data.origin_charge * req_data.neighbor_charge;
      qq_abs = qq[31] ? (32'd0 - 32'(qq)) : 32'(qq);
   end

   // Operand and result shaping around the shared multiplier.
   always_comb begin
      md_next   = (axis_ff == AXIS_X) ? md_ff[AXIS_Y] : md_ff[AXIS_Z];
      fs_mag    = fshift_ff[31] ? (32'd0 - fshift_ff) : fshift_ff;
      g_mag     = g_ff[49] ? (50'd0 - g_ff) : g_ff;
      fs_term   = mul_prod[63:16];
      h_val     = rom_ff[63:32];

      // The kernel product is capped at 2^62 after the Q16 shift.
      kernel_raw = mul_prod[79:16];
      if (mul_prod[127:80] != '0 || kernel_raw > KERNEL_CAP) begin
         m2_sat = KERNEL_CAP[62:0];
      end else begin
         m2_sat = kernel_raw[62:0];
      end

      // The per-axis force is capped at 2^47 after the Q8 shift.
      force_raw = mul_prod[71:8];
      if (mul_prod[127:72] != '0 || force_raw > FORCE_CAP) begin
         c_sat = FORCE_CAP[47:0];
      end else begin
         c_sat = force_raw[47:0];
      end

      // The table covers r2 below 256; anything beyond uses the last entry.
      in_cutoff = near_ff && (ss_ff < {2'b00, cutoff_ff, 16'd0});
      if (ss_ff[49:40] != '0) begin
         table_idx = '1;
      end else begin
         table_idx = ss_ff[39 -: TABLE_AW];
      end

      // Signed saturating accumulate. A first pair starts from zero, as does an
      // entry never written since reset.
      c_neg    = qq_neg_ff ^ g_ff[49] ^ dneg_ff[axis_ff];
      c_signed = c_neg ? (49'd0 - {1'b0, c_ff}) : {1'b0, c_ff};
      sum_old  = (sum_valid_ff[axis_ff] && !first_ff) ? sum_rdata : '0;
      sum_wide = $signed({{2{sum_old[47]}}, sum_old}) + $signed({c_signed[48], c_signed});
      if (sum_wide > SUM_HI) begin
         sum_sat = SUM_HI[47:0];
      end else if (sum_wide < SUM_LO) begin
         sum_sat = SUM_LO[47:0];
      end else begin
         sum_sat = sum_wide[47:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      sum_valid_in = sum_valid_ff;
      mul_start_in = 1'b0;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      md_in        = md_ff;
      dneg_in      = dneg_ff;
      near_in      = near_ff;
      hit_in       = hit_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      qq_mag_in    = qq_mag_ff;
      qq_neg_in    = qq_neg_ff;
      ss_in        = ss_ff;
      g_in         = g_ff;
      m2_in        = m2_ff;
      c_in         = c_ff;
      res_in       = res_ff;
      sum_we       = 1'b0;
      sum_wdata    = sum_sat;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               md_in[AXIS_X] = mag_x[23:0];
               md_in[AXIS_Y] = mag_y[23:0];
               md_in[AXIS_Z] = mag_z[23:0];
               dneg_in       = {d_z[32], d_y[32], d_x[32]};
               // A component of 256 or more can never fall inside the cutoff.
               near_in       = (mag_x[32:24] == '0) && (mag_y[32:24] == '0)
                             && (mag_z[32:24] == '0);
               qq_mag_in     = qq_abs[30:0];
               qq_neg_in     = qq[31];
               first_in      = req_data.first_neighbor;
               last_in       = req_data.last_neighbor;
               ss_in         = '0;
               axis_in       = AXIS_X;
               mul_start_in  = 1'b1;
               mul_a_in      = {40'd0, mag_x[23:0]};
               mul_b_in      = {40'd0, mag_x[23:0]};
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               ss_in = ss_ff + {2'b00, mul_prod[47:0]};
               if (axis_ff == AXIS_Z) begin
                  axis_in  = AXIS_X;
                  state_in = ST_CUTOFF;
               end else begin
                  axis_in      = axis_ff + AXIS_AW'(1);
                  mul_start_in = 1'b1;
                  mul_a_in     = {40'd0, md_next};
                  mul_b_in     = {40'd0, md_next};
               end
            end
         end
         ST_CUTOFF: begin
            // The table read issued here lands in rom_ff on the next cycle.
            hit_in = in_cutoff;
            if (in_cutoff) begin
               state_in = ST_TABLE;
            end else begin
               c_in     = '0;
               state_in = ST_SUM_READ;
            end
         end
         ST_TABLE: begin
            mul_start_in = 1'b1;
            mul_a_in     = {32'd0, fs_mag};
            mul_b_in     = {32'd0, rom_ff[31:0]};
            state_in     = ST_SHIFT_MUL;
         end
         ST_SHIFT_MUL: begin
            if (mul_done) begin
               if (fshift_ff[31]) begin
                  g_in = {18'd0, h_val} - {2'b00, fs_term};
               end else begin
                  g_in = {18'd0, h_val} + {2'b00, fs_term};
               end
               mul_start_in = 1'b1;
               mul_a_in     = {32'd0, coulomb_ff};
               mul_b_in     = {33'd0, qq_mag_ff};
               state_in     = ST_CHARGE_MUL;
            end
         end
         ST_CHARGE_MUL: begin
            if (mul_done) begin
               mul_start_in = 1'b1;
               mul_a_in     = {18'd0, mul_prod[61:16]};
               mul_b_in     = {14'd0, g_mag};
               state_in     = ST_KERNEL_MUL;
            end
         end
         ST_KERNEL_MUL: begin
            if (mul_done) begin
               m2_in        = m2_sat;
               axis_in      = AXIS_X;
               mul_start_in = 1'b1;
               mul_a_in     = {1'b0, m2_sat};
               mul_b_in     = {40'd0, md_ff[AXIS_X]};
               state_in     = ST_AXIS_MUL;
            end
         end
         ST_AXIS_MUL: begin
            if (mul_done) begin
               c_in     = c_sat;
               state_in = ST_SUM_READ;
            end
         end
         ST_SUM_READ: begin
            state_in = ST_SUM_WRITE;
         end
         ST_SUM_WRITE: begin
            sum_we                = 1'b1;
            sum_valid_in[axis_ff] = 1'b1;
            res_in[axis_ff]       = sum_sat;
            if (axis_ff == AXIS_Z) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else begin
               axis_in = axis_ff + AXIS_AW'(1);
               if (hit_ff) begin
                  mul_start_in = 1'b1;
                  mul_a_in     = {1'b0, m2_ff};
                  mul_b_in     = {40'd0, md_next};
                  state_in     = ST_AXIS_MUL;
               end else begin
                  state_in = ST_SUM_READ;
               end
            end
         end
         ST_EMIT: begin
            // Wait only while the output register still holds an untaken result.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.force_x = res_ff[AXIS_X];
               rsp_data_in.force_y = res_ff[AXIS_Y];
               rsp_data_in.force_z = res_ff[AXIS_Z];
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         sum_valid_ff <= '0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cutoff_ff    <= '0;
         coulomb_ff   <= '0;
         fshift_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         sum_valid_ff <= sum_valid_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_CUTOFF_SQUARED:   cutoff_ff  <= csr_wdata;
               CSR_COULOMB_CONSTANT: coulomb_ff <= csr_wdata;
               CSR_FORCE_SHIFT:      fshift_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      md_ff       <= md_in;
      dneg_ff     <= dneg_in;
      near_ff     <= near_in;
      hit_ff      <= hit_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      qq_mag_ff   <= qq_mag_in;
      qq_neg_ff   <= qq_neg_in;
      ss_ff       <= ss_in;
      g_ff        <= g_in;
      m2_ff       <= m2_in;
      c_ff        <= c_in;
      res_ff      <= res_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_CUTOFF) begin
         rom_ff <= KERNEL_ROM[table_idx];
      end
   end

   wcfa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .op_a    (mul_a_ff),
      .op_b    (mul_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // The three running sums live in a small RAM, read then written back per axis.
   wcfa_ram #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (AXIS_COUNT)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (axis_ff),
      .wr_data (sum_wdata),
      .rd_addr (axis_ff),
      .rd_data (sum_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/wcfa_ram.sv =====
// Generic single-port-write, registered-read RAM.
module wcfa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 3
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wcfa_mul.sv =====
// Multi-cycle 64x64 unsigned multiplier built on one registered 32x32 partial product.
module wcfa_mul
   import wcfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic         done,
   output logic [127:0] product
);

   localparam logic [2:0] STEP_LAST = 3'd4;

   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic         busy_ff, busy_in;
   logic [2:0]   step_ff, step_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   pp_shift_ff, pp_shift_in;
   logic         pp_valid_ff, pp_valid_in;
   logic [127:0] acc_ff, acc_in;
   logic         done_ff, done_in;
   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [127:0] pp_placed;

   always_comb begin
      a_half      = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half      = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp_in       = {32'd0, a_half} * {32'd0, b_half};
      pp_shift_in = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
      pp_valid_in = busy_ff && (step_ff != STEP_LAST);
      done_in     = busy_ff && (step_ff == STEP_LAST);

      case (pp_shift_ff)
         2'd0:    pp_placed = {64'd0, pp_ff};
         2'd1:    pp_placed = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_placed = {pp_ff, 64'd0};
         default: pp_placed = '0;
      endcase

      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      acc_in  = pp_valid_ff ? acc_ff + pp_placed : acc_ff;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         pp_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         pp_valid_ff <= pp_valid_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      step_ff     <= step_in;
      pp_ff       <= pp_in;
      pp_shift_ff <= pp_shift_in;
      acc_ff      <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
